### rtl/gfnpf_pkg.sv
// Shared widths, register indexes and reset values of the four-neighbour peak finder.
package gfnpf_pkg;

  localparam int ELEV_W     = 16;
  localparam int PEAK_ROW_W = 10;
  localparam int PEAK_COL_W = 5;

  localparam int ROW_CFG_W  = 11;
  localparam int COL_CFG_W  = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

  localparam logic [ROW_CFG_W-1:0] ROW_COUNT_RST = 11'd20;
  localparam logic [COL_CFG_W-1:0] COL_COUNT_RST = 6'd20;

endpackage

### rtl/gfnpf_line_mem.sv
// Two line stores (row being judged and the row above it) with registered reads.
module gfnpf_line_mem
  import gfnpf_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [ELEV_W-1:0] wr_prior,
  input  logic [ELEV_W-1:0] wr_older,
  output logic [ELEV_W-1:0] rd_prior,
  output logic [ELEV_W-1:0] rd_right,
  output logic [ELEV_W-1:0] rd_older
);

  logic [ELEV_W-1:0] prior_mem [DEPTH];
  logic [ELEV_W-1:0] older_mem [DEPTH];
  logic [ELEV_W-1:0] rd_prior_r;
  logic [ELEV_W-1:0] rd_right_r;
  logic [ELEV_W-1:0] rd_older_r;
  logic [AW-1:0]     rd_addr_right;

  // Right neighbour address; wraps past the end, where it is never used.
  assign rd_addr_right = rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prior_mem[wr_addr] <= wr_prior;
      older_mem[wr_addr] <= wr_older;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prior_r <= prior_mem[rd_addr];
      rd_right_r <= prior_mem[rd_addr_right];
      rd_older_r <= older_mem[rd_addr];
    end
  end

  assign rd_prior = rd_prior_r;
  assign rd_right = rd_right_r;
  assign rd_older = rd_older_r;

endmodule

### rtl/grid_four_neighbour_peak_finder.sv
// Four-neighbour peak finder: takes elevations of a row_count by col_count grid in raster
// order and returns, in row-major order, the row and column of every cell that is not
// smaller than any of its up, down, left and right neighbours inside the grid. A cell is
// judged when the cell below it arrives; after the last cell of the frame the last row is
// judged from the line stores and a frame_done beat closes the frame. Rate: one cell per
// cycle, set by the read-evaluate-write loop over the line store memories, while out_ready
// keeps the output free; with one or two columns a cell may wait because its store read
// must follow the write-back of the cell before it. No cell is taken during the last-row
// sweep and the frame_done beat that follow the last cell of a frame. A result is judged
// in the evaluate stage from the registered store reads, then held in the output register
// while out_ready is low. Writing either register restarts the frame at row 0, column 0;
// out-of-range counts clamp to 1..MAX_ROWS and 1..MAX_COLS.
module grid_four_neighbour_peak_finder
  import gfnpf_pkg::*;
#(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cell input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ELEV_W-1:0]     in_elevation,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PEAK_ROW_W-1:0] out_peak_row,
  output logic [PEAK_COL_W-1:0] out_peak_col,
  output logic                  out_frame_done,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  localparam int CC_W   = (COLS_W > COL_CFG_W) ? COLS_W : COL_CFG_W;
  localparam int RC_W   = (ROWS_W > ROW_CFG_W) ? ROWS_W : ROW_CFG_W;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,  // take cells
    ST_FLUSH = 3'b010,  // sweep the last row
    ST_FIN   = 3'b100   // send frame_done
  } state_t;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_FLUSH,
    OP_DONE
  } op_kind_t;

  // configuration
  logic [ROW_CFG_W-1:0] row_count_r;
  logic [COL_CFG_W-1:0] col_count_r;
  logic [RC_W-1:0]      row_cfg_ext;
  logic [CC_W-1:0]      col_cfg_ext;
  logic [RC_W-1:0]      eff_rows;
  logic [CC_W-1:0]      eff_cols;

  // sequencing
  state_t               st_r, st_nxt;
  logic [ROW_W-1:0]     row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic                 last_col;
  logic                 last_row;
  logic                 has_right;
  logic                 hazard;
  logic                 in_accept;
  logic                 fl_issue;
  logic                 dn_issue;
  logic                 issue;

  // evaluate stage (memory read data arrives here)
  logic                 b_valid_r, b_valid_nxt;
  op_kind_t             b_kind_r;
  logic [ROW_W-1:0]     b_row_r;
  logic [COL_W-1:0]     b_col_r;
  logic [ELEV_W-1:0]    b_elev_r;
  logic                 b_right_r;
  logic [ELEV_W-1:0]    left_r;
  logic                 b_go;
  logic                 b_free;
  logic                 b_emit;
  logic                 left_ok;
  logic                 right_ok;
  logic [PEAK_ROW_W-1:0] res_row;
  logic [PEAK_COL_W-1:0] res_col;
  logic                 res_done;

  // memory side
  logic [ELEV_W-1:0]    mem_prior;
  logic [ELEV_W-1:0]    mem_right;
  logic [ELEV_W-1:0]    mem_older;
  logic                 mem_wr_en;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [PEAK_ROW_W-1:0] out_row_r;
  logic [PEAK_COL_W-1:0] out_col_r;
  logic                 out_done_r;
  logic                 out_free;

  // Clamp the configured counts into 1..MAX.
  assign row_cfg_ext = RC_W'(row_count_r);
  assign col_cfg_ext = CC_W'(col_count_r);
  assign eff_rows = (row_cfg_ext == '0) ? RC_W'(1) :
                    (row_cfg_ext > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : row_cfg_ext;
  assign eff_cols = (col_cfg_ext == '0) ? CC_W'(1) :
                    (col_cfg_ext > CC_W'(MAX_COLS)) ? CC_W'(MAX_COLS) : col_cfg_ext;

  assign last_col  = (CC_W'(col_cnt_r) == (eff_cols - CC_W'(1)));
  assign last_row  = (RC_W'(row_cnt_r) == (eff_rows - RC_W'(1)));
  assign has_right = (CC_W'(col_cnt_r) < (eff_cols - CC_W'(1)));

  // Interlock: a read of the entry (or its right neighbour) that the evaluate stage
  // is about to write back waits for that write-back. Only short rows hit this.
  assign hazard = b_valid_r && (b_kind_r == OP_ITEM) &&
                  ((b_col_r == col_cnt_r) || (b_col_r == (col_cnt_r + COL_W'(1))));

  assign out_free = !out_valid_r || out_ready;
  assign b_go     = b_valid_r && out_free;
  assign b_free   = !b_valid_r || b_go;

  assign in_ready  = (st_r == ST_RUN) && b_free && !hazard;
  assign in_accept = in_valid && in_ready;
  assign fl_issue  = (st_r == ST_FLUSH) && b_free && !hazard;
  assign dn_issue  = (st_r == ST_FIN) && b_free;
  assign issue     = in_accept || fl_issue || dn_issue;

  // Advance the row and column position and the frame state.
  always_comb begin
    st_nxt      = st_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    case (st_r)
      ST_RUN: begin
        if (in_accept) begin
          if (last_col) begin
            col_cnt_nxt = '0;
            // hold the row index of the last row for the sweep
            if (last_row) begin
              st_nxt = ST_FLUSH;
            end else begin
              row_cnt_nxt = row_cnt_r + ROW_W'(1);
            end
          end else begin
            col_cnt_nxt = col_cnt_r + COL_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (fl_issue) begin
          if (last_col) begin
            col_cnt_nxt = '0;
            st_nxt      = ST_FIN;
          end else begin
            col_cnt_nxt = col_cnt_r + COL_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (dn_issue) begin
          row_cnt_nxt = '0;
          col_cnt_nxt = '0;
          st_nxt      = ST_RUN;
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
    // A register write starts a new frame.
    if (cfg_wr_en) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else begin
      st_r      <= st_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      if (cfg_wr_en) begin
        case (cfg_wr_index)
          CFG_ROW_COUNT: row_count_r <= cfg_wr_data[ROW_CFG_W-1:0];
          CFG_COL_COUNT: col_count_r <= cfg_wr_data[COL_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  gfnpf_line_mem #(
    .DEPTH (MAX_COLS),
    .AW    (COL_W)
  ) u_line_mem (
    .clk      (clk),
    .rd_en    (issue),
    .rd_addr  (col_cnt_r),
    .wr_en    (mem_wr_en),
    .wr_addr  (b_col_r),
    .wr_prior (b_elev_r),
    .wr_older (mem_prior),
    .rd_prior (mem_prior),
    .rd_right (mem_right),
    .rd_older (mem_older)
  );

  // Write back: the judged row moves to the older store, the new cell takes its place.
  assign mem_wr_en = b_go && (b_kind_r == OP_ITEM);

  // Evaluate stage: judge the cell read from the prior store against its neighbours.
  assign left_ok  = (b_col_r == '0) || (left_r <= mem_prior);
  assign right_ok = !b_right_r || (mem_right <= mem_prior);

  always_comb begin
    b_emit   = 1'b0;
    res_row  = '0;
    res_col  = '0;
    res_done = 1'b0;
    case (b_kind_r)
      OP_ITEM: begin
        // row 0 has nothing above to judge; up counts from row 2 on
        b_emit  = (b_row_r != '0) &&
                  ((b_row_r == ROW_W'(1)) || (mem_older <= mem_prior)) &&
                  left_ok && right_ok && (b_elev_r <= mem_prior);
        res_row = PEAK_ROW_W'(b_row_r - ROW_W'(1));
        res_col = PEAK_COL_W'(b_col_r);
      end
      OP_FLUSH: begin
        // last row: no down neighbour
        b_emit  = ((b_row_r == '0) || (mem_older <= mem_prior)) && left_ok && right_ok;
        res_row = PEAK_ROW_W'(b_row_r);
        res_col = PEAK_COL_W'(b_col_r);
      end
      OP_DONE: begin
        b_emit   = 1'b1;
        res_done = 1'b1;
      end
      default: begin
        b_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (issue) begin
      b_valid_nxt = 1'b1;
    end else if (b_go) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_go && b_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the evaluate stage with the operation whose reads were just issued.
  always_ff @(posedge clk) begin
    if (issue) begin
      b_row_r   <= row_cnt_r;
      b_col_r   <= col_cnt_r;
      b_elev_r  <= in_elevation;
      b_right_r <= has_right;
      if (in_accept) begin
        b_kind_r <= OP_ITEM;
      end else if (fl_issue) begin
        b_kind_r <= OP_FLUSH;
      end else begin
        b_kind_r <= OP_DONE;
      end
    end
  end

  // Hold the judged cell as the left neighbour of the next one.
  always_ff @(posedge clk) begin
    if (b_go) begin
      left_r <= mem_prior;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_emit) begin
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_done_r <= res_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_row   = out_row_r;
  assign out_peak_col   = out_col_r;
  assign out_frame_done = out_done_r;

endmodule

### dv/tb_grid_four_neighbour_peak_finder.sv
// Self-checking testbench for the four-neighbour peak finder: directed grids, then random frames.
`timescale 1ns / 1ps

module tb_grid_four_neighbour_peak_finder;
  import gfnpf_pkg::*;

  localparam int GRID_COLS   = 32;
  localparam int GRID_ROWS   = 1024;
  // Allow for the last-row sweep plus the result pipe (evaluate stage, output register) before touching registers.
  localparam int DRAIN_WAIT  = GRID_COLS + 8;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [PEAK_ROW_W-1:0] row;
    logic [PEAK_COL_W-1:0] col;
    logic                  done;
  } peak_beat_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [ELEV_W-1:0]     in_elevation = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [PEAK_ROW_W-1:0] out_peak_row;
  logic [PEAK_COL_W-1:0] out_peak_col;
  logic                  out_frame_done;
  logic                  cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_wr_index = CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

  grid_four_neighbour_peak_finder #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_elevation  (in_elevation),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_peak_row  (out_peak_row),
    .out_peak_col  (out_peak_col),
    .out_frame_done(out_frame_done),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_index  (cfg_wr_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cells waiting to be driven, and peak beats the block still owes us.
  logic [ELEV_W-1:0] cell_backlog [$];
  peak_beat_t        pending_peaks [$];
  peak_beat_t        oldest_peak;

  // Shadow of the block: register copies, line stores and raster position.
  logic [ROW_CFG_W-1:0] row_len = ROW_COUNT_RST;
  logic [COL_CFG_W-1:0] col_len = COL_COUNT_RST;
  bit   [ELEV_W-1:0]    judged_row [GRID_COLS];
  bit   [ELEV_W-1:0]    upper_row  [GRID_COLS];
  bit   [ELEV_W-1:0]    left_elev;
  int unsigned          row_pos = 0;
  int unsigned          col_pos = 0;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cells_taken    = 0;
  int unsigned peaks_seen     = 0;
  int unsigned frames_closed  = 0;
  int unsigned cycle_count    = 0;

  function automatic int unsigned clamp_len(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_cells();
    return clamp_len(row_len, GRID_ROWS) * clamp_len(col_len, GRID_COLS);
  endfunction

  task automatic push_peak(input int unsigned r, input int unsigned c, input logic done);
    peak_beat_t beat;
    beat.row  = r[PEAK_ROW_W-1:0];
    beat.col  = c[PEAK_COL_W-1:0];
    beat.done = done;
    pending_peaks.push_back(beat);
  endtask

  // Judge the cell above the incoming one; on the last cell of a frame also sweep
  // the last row and close the frame.
  task automatic judge_cell(input logic [ELEV_W-1:0] elev);
    int unsigned       rows;
    int unsigned       cols;
    int unsigned       r;
    int unsigned       c;
    logic [ELEV_W-1:0] centre;
    bit                is_peak;
    rows = clamp_len(row_len, GRID_ROWS);
    cols = clamp_len(col_len, GRID_COLS);
    r = row_pos;
    c = col_pos;
    if (r > 0) begin
      centre  = judged_row[c];
      is_peak = 1'b1;
      if (r >= 2 && upper_row[c] > centre) is_peak = 1'b0;
      if (c > 0 && left_elev > centre) is_peak = 1'b0;
      if (c + 1 < cols && judged_row[c + 1] > centre) is_peak = 1'b0;
      if (elev > centre) is_peak = 1'b0;
      if (is_peak) push_peak(r - 1, c, 1'b0);
    end
    left_elev     = judged_row[c];
    upper_row[c]  = judged_row[c];
    judged_row[c] = elev;
    if (c + 1 >= cols) begin
      col_pos = 0;
      if (r + 1 >= rows) begin
        for (int unsigned j = 0; j < cols; j++) begin
          centre  = judged_row[j];
          is_peak = 1'b1;
          if (r >= 1 && upper_row[j] > centre) is_peak = 1'b0;
          if (j > 0 && judged_row[j - 1] > centre) is_peak = 1'b0;
          if (j + 1 < cols && judged_row[j + 1] > centre) is_peak = 1'b0;
          if (is_peak) push_peak(r, j, 1'b0);
        end
        push_peak(0, 0, 1'b1);
        row_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Driver: advance the cell stream; hold valid and payload until the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        judge_cell(in_elevation);
        cells_taken++;
      end
      if (!in_valid || in_ready) begin
        if (cell_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid     <= 1'b1;
          in_elevation <= cell_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest owed beat, then pick the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_peaks.size() == 0) begin
          report_mismatch($sformatf("unexpected beat row %0d col %0d done %0b",
                                    out_peak_row, out_peak_col, out_frame_done));
        end else begin
          oldest_peak = pending_peaks.pop_front();
          if (out_peak_row !== oldest_peak.row)
            report_mismatch($sformatf("peak_row got %0d want %0d",
                                      out_peak_row, oldest_peak.row));
          if (out_peak_col !== oldest_peak.col)
            report_mismatch($sformatf("peak_col got %0d want %0d",
                                      out_peak_col, oldest_peak.col));
          if (out_frame_done !== oldest_peak.done)
            report_mismatch($sformatf("frame_done got %0b want %0b",
                                      out_frame_done, oldest_peak.done));
          if (oldest_peak.done) frames_closed++;
          else peaks_seen++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               pending_peaks.size());
      $display("tb_grid_four_neighbour_peak_finder NOT OK");
      $finish;
    end
  end

  // Pacing: 0 = sender gaps light, receiver stalls heavy; 1 = the reverse; 2 = no gaps.
  task automatic set_pacing(input int mode);
    case (mode)
      0: begin send_gap_pct = 34; recv_stall_pct = 65; end
      1: begin send_gap_pct = 65; recv_stall_pct = 34; end
      default: begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // Wait for the stream to drain, then give the block time to finish an unjudged cell.
  task automatic settle();
    while (cell_backlog.size() != 0 || in_valid || pending_peaks.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= index;
    cfg_wr_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (index == CFG_ROW_COUNT) row_len = ROW_CFG_W'(value);
    else col_len = COL_CFG_W'(value);
    // Any write restarts the frame at the top-left cell.
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic apply_setting(input int unsigned rows_w, input int unsigned cols_w);
    settle();
    write_reg(CFG_ROW_COUNT, rows_w);
    write_reg(CFG_COL_COUNT, cols_w);
  endtask

  function automatic logic [ELEV_W-1:0] pick_elev(input int unsigned spread);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return ELEV_W'($urandom_range(0, spread));
  endfunction

  task automatic queue_cells(input int unsigned n, input int unsigned spread);
    repeat (n) cell_backlog.push_back(pick_elev(spread));
  endtask

  initial begin
    int unsigned rows_w;
    int unsigned cols_w;
    int unsigned spread;
    int unsigned n;
    int unsigned frame_no;
    int unsigned random_cells;
    frame_no     = 0;
    random_cells = 0;
    set_pacing(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one-cell grids, including zero counts that act as one.
    apply_setting(1, 1);
    cell_backlog = '{16'd0};
    apply_setting(0, 0);
    cell_backlog = '{16'hFFFF};
    // Checkerboard of the elevation extremes on a 3 x 3 grid.
    apply_setting(3, 3);
    for (int i = 0; i < 9; i++) cell_backlog.push_back((i % 2) ? 16'hFFFF : 16'h0000);
    // Single row: judged only at the last cell, with a tie between neighbours.
    apply_setting(1, 4);
    cell_backlog = '{16'd5, 16'd9, 16'd9, 16'd1};
    // Single column: only up and down neighbours count.
    apply_setting(4, 1);
    cell_backlog = '{16'd3, 16'd7, 16'd7, 16'd2};
    // Cut a frame short with a register write, then run a flat grid of ties.
    apply_setting(3, 2);
    cell_backlog = '{16'd1, 16'd2, 16'd3};
    apply_setting(2, 2);
    cell_backlog = '{16'd8, 16'd8, 16'd8, 16'd8};

    // Random frames; each setting runs one to three whole frames, some cut short.
    while (random_cells < 290) begin
      frame_no++;
      if (random_cells < 97) set_pacing(0);
      else if (random_cells < 194) set_pacing(1);
      else set_pacing(2);
      if (frame_no == 1) begin
        // Flat 2 x 32 grid: the last cell owes the longest burst of beats.
        rows_w = 2;
        cols_w = 40;
        spread = 0;
      end else if (frame_no == 4) begin
        rows_w = 1;
        cols_w = 63;
        spread = 3;
      end else begin
        rows_w = $urandom_range(0, 6);
        cols_w = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) begin
          // Column count above the limit; keep such frames short.
          rows_w = $urandom_range(0, 2);
          cols_w = $urandom_range(33, 63);
        end
        case ($urandom_range(0, 3))
          0: spread = 1;
          1: spread = 3;
          2: spread = 255;
          default: spread = 65535;
        endcase
      end
      apply_setting(rows_w, cols_w);
      repeat ($urandom_range(1, 3)) begin
        if (random_cells < 290) begin
          n = frame_cells();
          queue_cells(n, spread);
          random_cells += n;
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        n = frame_cells();
        n = (n > 1) ? $urandom_range(1, n - 1) : 1;
        queue_cells(n, spread);
        random_cells += n;
      end
    end

    while (cell_backlog.size() != 0 || in_valid || pending_peaks.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("ran %0d frame settings over %0d cells", frame_no + 7, cells_taken);
    $display("checked %0d peak beats and %0d frame ends", peaks_seen, frames_closed);
    if (mismatch_count == 0) begin
      $display("tb_grid_four_neighbour_peak_finder OK");
    end else begin
      $display("tb_grid_four_neighbour_peak_finder NOT OK");
    end
    $finish;
  end

endmodule
